[design/vsb_pkg.sv]
// Shared types, codes and helpers of the vertex skin blend unit.
package vsb_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_WORLD = 2'd0;
  localparam logic [1:0] FUNC_INV   = 2'd1;
  localparam logic [1:0] FUNC_SKIN  = 2'd2;

  // Weights are unsigned Q1.15
  localparam int WEIGHT_FRAC = 15;

  // Kind of product handled by the multiply-accumulate unit
  typedef enum logic [1:0] {
    OP_MAT,
    OP_VEC,
    OP_WGT
  } op_kind_t;

  // One multiply-accumulate operation issued by the sequencer
  typedef struct packed {
    logic               valid;
    logic               clear;
    op_kind_t           kind;
    logic               first;
    logic               last;
    logic [1:0]         col;
    logic [1:0]         row;
    logic signed [31:0] operand;
  } vsb_op_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[design/vsb_in_if.sv]
// Input item channel of the vertex skin blend unit.
interface vsb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [9:0]         matrix_addr;
  logic signed [31:0] elem_value;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic [23:0]        bone_ids;
  logic [63:0]        weights;
  logic [2:0]         bone_count;

  modport source (
    output valid, func, matrix_addr, elem_value, vx, vy, vz, bone_ids, weights, bone_count,
    input  ready
  );
  modport sink (
    input  valid, func, matrix_addr, elem_value, vx, vy, vz, bone_ids, weights, bone_count,
    output ready
  );
endinterface

[design/vsb_out_if.sv]
// Result channel of the vertex skin blend unit.
interface vsb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               bad_bone;

  modport source (
    output valid, out_x, out_y, out_z, bad_bone,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, bad_bone,
    output ready
  );
endinterface

[design/vsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/vsb_mac.sv]
// Shared multiply, floor-shift and saturating accumulate unit.
module vsb_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vsb_pkg::vsb_op_t      op,
  input  logic signed [31:0]    w_data,
  input  logic signed [31:0]    b_data,
  output logic signed [31:0]    acc_x,
  output logic signed [31:0]    acc_y,
  output logic signed [31:0]    acc_z,
  output logic                  busy
);

  vsb_pkg::vsb_op_t   s1;
  vsb_pkg::vsb_op_t   s2;
  logic signed [63:0] prod;
  logic signed [63:0] sum;
  logic signed [31:0] m_row [4];
  logic signed [31:0] p;
  logic signed [31:0] acc [3];

  logic signed [31:0] a_sel;
  logic signed [31:0] b_sel;
  logic signed [63:0] shifted;
  logic signed [63:0] sum_tot;
  logic signed [31:0] acc_cur;
  logic signed [63:0] acc_tot;

  // Select multiplier operands for the operation in stage one
  always_comb begin
    unique case (s1.kind)
      vsb_pkg::OP_MAT: begin
        a_sel = w_data;
        b_sel = b_data;
      end
      vsb_pkg::OP_VEC: begin
        a_sel = m_row[s1.col];
        b_sel = s1.operand;
      end
      vsb_pkg::OP_WGT: begin
        a_sel = p;
        b_sel = s1.operand;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // Floor-shift the product and form running sums
  always_comb begin
    shifted = (s2.kind == vsb_pkg::OP_WGT) ? (prod >>> vsb_pkg::WEIGHT_FRAC)
                                           : (prod >>> FRAC_BITS);
    sum_tot = s2.first ? shifted : (sum + shifted);
    acc_cur = acc[s2.row];
    acc_tot = {{32{acc_cur[31]}}, acc_cur} + shifted;
  end

  // Advance the two stages and write back finished sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= op;
      s2 <= s1;
    end
    prod <= a_sel * b_sel;
    if (op.clear) begin
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end
    if (s2.valid) begin
      sum <= sum_tot;
      if (s2.last) begin
        unique case (s2.kind)
          vsb_pkg::OP_MAT: m_row[s2.col] <= vsb_pkg::sat32(sum_tot);
          vsb_pkg::OP_VEC: p <= vsb_pkg::sat32(sum_tot);
          vsb_pkg::OP_WGT: acc[s2.row] <= vsb_pkg::sat32(acc_tot);
          default: ;
        endcase
      end
    end
  end

  assign acc_x = acc[0];
  assign acc_y = acc[1];
  assign acc_z = acc[2];
  assign busy  = s1.valid || s2.valid;

endmodule

[design/vsb_seq.sv]
// Sequencer: walks influences, rows and products and holds the result register.
module vsb_seq #(
  parameter int MAX_BONES      = 64,
  parameter int MAX_INFLUENCES = 4,
  parameter int FRAC_BITS      = 16,
  localparam int STORE_AW      = $clog2(MAX_BONES * 16)
) (
  input  logic                 clk,
  input  logic                 rst,
  vsb_in_if.sink               item,
  vsb_out_if.source            result,
  input  logic [6:0]           num_bones,
  output vsb_pkg::vsb_op_t     op,
  output logic [STORE_AW-1:0]  w_addr,
  output logic [STORE_AW-1:0]  b_addr,
  input  logic                 busy,
  input  logic signed [31:0]   acc_x,
  input  logic signed [31:0]   acc_y,
  input  logic signed [31:0]   acc_z
);

  // Operation index within one row: 16 matrix products, 4 vector products,
  // one gap for the vector sum to settle, one weight product
  localparam logic [4:0] OPI_VEC = 5'd16;
  localparam logic [4:0] OPI_GAP = 5'd20;
  localparam logic [4:0] OPI_WGT = 5'd21;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t             state;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic [23:0]        ids;
  logic [63:0]        wts;
  logic [2:0]         cnt;
  logic [2:0]         slot;
  logic [1:0]         row;
  logic [4:0]         opi;
  logic [5:0]         bone;
  logic               bad;
  logic               res_valid;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic               res_bad;

  logic [5:0]         id_sel;
  logic [15:0]        w_sel;
  logic               bone_ok;
  logic signed [31:0] v_sel;

  assign id_sel  = ids[slot[1:0] * 6 +: 6];
  assign w_sel   = wts[slot[1:0] * 16 +: 16];
  assign bone_ok = ({3'b0, id_sel} < {2'b0, num_bones}) &&
                   ({3'b0, id_sel} < 9'(MAX_BONES));

  // Pick the vertex component, with w fixed at 1.0
  always_comb begin
    case (opi[1:0])
      2'd0:    v_sel = vx;
      2'd1:    v_sel = vy;
      2'd2:    v_sel = vz;
      default: v_sel = ONE;
    endcase
  end

  // Issue one operation per cycle while running, except in the gap before the weight product
  always_comb begin
    op       = '0;
    op.clear = (state == S_IDLE) && item.valid && (item.func == vsb_pkg::FUNC_SKIN);
    op.row   = row;
    w_addr   = STORE_AW'({bone, opi[1:0], row});
    b_addr   = STORE_AW'({bone, opi[3:2], opi[1:0]});
    if (state == S_RUN) begin
      if (opi < OPI_VEC) begin
        op.valid = 1'b1;
        op.kind  = vsb_pkg::OP_MAT;
        op.col   = opi[3:2];
        op.first = (opi[1:0] == 2'd0);
        op.last  = (opi[1:0] == 2'd3);
      end else if (opi < OPI_GAP) begin
        op.valid   = 1'b1;
        op.kind    = vsb_pkg::OP_VEC;
        op.col     = opi[1:0];
        op.first   = (opi[1:0] == 2'd0);
        op.last    = (opi[1:0] == 2'd3);
        op.operand = v_sel;
      end else if (opi == OPI_WGT) begin
        op.valid   = 1'b1;
        op.kind    = vsb_pkg::OP_WGT;
        op.first   = 1'b1;
        op.last    = 1'b1;
        op.operand = {16'b0, w_sel};
      end
    end
  end

  assign item.ready      = (state == S_IDLE);
  assign result.valid    = res_valid;
  assign result.out_x    = res_x;
  assign result.out_y    = res_y;
  assign result.out_z    = res_z;
  assign result.bad_bone = res_bad;

  // Hold state, counters and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid && (item.func == vsb_pkg::FUNC_SKIN)) begin
            vx    <= item.vx;
            vy    <= item.vy;
            vz    <= item.vz;
            ids   <= item.bone_ids;
            wts   <= item.weights;
            cnt   <= (item.bone_count > 3'(MAX_INFLUENCES)) ? 3'(MAX_INFLUENCES)
                                                            : item.bone_count;
            slot  <= '0;
            bad   <= 1'b0;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (slot >= cnt) begin
            state <= S_DRAIN;
          end else if (!bone_ok) begin
            bad  <= 1'b1;
            slot <= slot + 3'd1;
          end else begin
            bone  <= id_sel;
            row   <= '0;
            opi   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (opi == OPI_WGT) begin
            opi <= '0;
            if (row == 2'd2) begin
              slot  <= slot + 3'd1;
              state <= S_SLOT;
            end else begin
              row <= row + 2'd1;
            end
          end else begin
            opi <= opi + 5'd1;
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_x     <= acc_x;
            res_y     <= acc_y;
            res_z     <= acc_z;
            res_bad   <= bad;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The pipeline is empty before a result is taken from the accumulators
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !busy)
    else $error("result captured with operations in flight");

  // A skin transaction closes the input until its result is queued
  a_skin_busy: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.func == vsb_pkg::FUNC_SKIN)) |=>
    ((state == S_SLOT) && !item.ready))
    else $error("skin transaction did not start the sequence");

  // Running only on a used influence and one of three rows
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((row != 2'd3) && (slot < cnt)))
    else $error("sequencer ran outside its influence or row range");
`endif

endmodule

[design/vertex_skin_blend_unit.sv]
// Top level of the vertex skin blend unit: stores, configuration and sequencing.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+--------------------------------------------
//   item     | in  | valid / ready  | func, matrix_addr, elem_value, vx, vy, vz,
//            |     |                | bone_ids, weights, bone_count
//   result   | out | valid / ready  | out_x, out_y, out_z, bad_bone
//   cfg      | in  | cfg_we         | cfg_data (num_bones)
//
// A load transaction writes the store on acceptance.
// A skin transaction walks each used influence and skips one whose bone id is bad:
// one 32x32 multiplier does one of the 63 products of an influence per cycle (save
// in the gap before each weight product), fed from one read port of each store.
// Reset clears control state and sets num_bones to 64; the stores are not cleared.
// A stalled result waits in the output register while the next item is accepted.
module vertex_skin_blend_unit #(
  parameter int MAX_BONES      = 64,
  parameter int MAX_INFLUENCES = 4,
  parameter int FRAC_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst,
  vsb_in_if.sink     item,
  vsb_out_if.source  result,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  localparam int STORE_DEPTH = MAX_BONES * 16;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  logic [6:0]          num_bones;
  logic                load_ok;
  logic                accept;
  logic                we_w;
  logic                we_b;
  logic [STORE_AW-1:0] waddr;
  logic [STORE_AW-1:0] w_addr;
  logic [STORE_AW-1:0] b_addr;
  logic signed [31:0]  w_data;
  logic signed [31:0]  b_data;
  vsb_pkg::vsb_op_t    op;
  logic                busy;
  logic signed [31:0]  acc_x;
  logic signed [31:0]  acc_y;
  logic signed [31:0]  acc_z;

  // Hold the bone count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bones <= 7'd64;
    end else if (cfg_we) begin
      num_bones <= cfg_data;
    end
  end

  // Decode load transactions; drop loads beyond the last bone slot of the stores
  assign accept  = item.valid && item.ready;
  assign load_ok = {3'b0, item.matrix_addr[9:4]} < 9'(MAX_BONES);
  assign we_w    = accept && load_ok && (item.func == vsb_pkg::FUNC_WORLD);
  assign we_b    = accept && load_ok && (item.func == vsb_pkg::FUNC_INV);
  assign waddr   = STORE_AW'(item.matrix_addr);

  vsb_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_world (
    .clk   (clk),
    .we    (we_w),
    .waddr (waddr),
    .wdata (item.elem_value),
    .raddr (w_addr),
    .rdata (w_data)
  );

  vsb_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_inv_base (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (item.elem_value),
    .raddr (b_addr),
    .rdata (b_data)
  );

  vsb_seq #(
    .MAX_BONES      (MAX_BONES),
    .MAX_INFLUENCES (MAX_INFLUENCES),
    .FRAC_BITS      (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .num_bones (num_bones),
    .op        (op),
    .w_addr    (w_addr),
    .b_addr    (b_addr),
    .busy      (busy),
    .acc_x     (acc_x),
    .acc_y     (acc_y),
    .acc_z     (acc_z)
  );

  vsb_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .w_data (w_data),
    .b_data (b_data),
    .acc_x  (acc_x),
    .acc_y  (acc_y),
    .acc_z  (acc_z),
    .busy   (busy)
  );

endmodule
